[src/cht_pkg.sv]
// shared constants and types for the chained hash table
`timescale 1ns / 1ps
package cht_pkg;
  localparam int BUCKETS      = 128;
  localparam int POOL_ENTRIES = 256;
  localparam int BW = $clog2(BUCKETS);
  localparam int NW = $clog2(POOL_ENTRIES);
  localparam int LW = NW + 1;
  localparam logic [LW-1:0] NIL = LW'(POOL_ENTRIES);

  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_ADD    = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NOTUSED  = 2'd3;

  typedef enum logic [3:0] {
    CMD_NONE, CMD_LATCH, CMD_RD_HEAD, CMD_RD_NODE, CMD_STEP,
    CMD_ADD_WR, CMD_ADD_PREV, CMD_DEL_RD, CMD_DEL_WR, CMD_INIT
  } cmd_t;

  typedef struct packed {
    logic       init_done;
    logic [1:0] op;
    logic       cur_nil;
    logic       match;
    logic       walk_limit;
    logic       free_empty;
    logic       tgt_used;
  } dp_status_t;
endpackage

[src/chained_hash_table_top.sv]
// top level of the separate-chaining hash table
//  channel | dir | tdata fields (low bit up)
//  in_     | in  | opcode, key_fd, key_condition, entry_data, target_node (66 -> 72)
//  out_    | out | status, node_index, found_fd, found_condition, found_data (66 -> 72)
// a lookup walks the chain from the bucket head, reading and comparing one node at a time;
// add links a new node at the chain head, delete unlinks the target by its prev and next links
// one item is in flight at a time: the next is taken only after out_tready takes the result
// after reset a clearing pass sets every bucket head to NIL and builds the free chain; no item taken then
// a finished result holds in the output register until out_tready
`timescale 1ns / 1ps
module chained_hash_table_top import cht_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,  // opcode, key_fd, key_condition, entry_data, target_node
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata  // status, node_index, found_fd, found_condition, found_data
);
  cmd_t       cmd;
  dp_status_t sts;
  logic       res_load;
  logic [1:0] res_status;
  logic [65:0] res_word;

  cht_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready,
    .sts, .cmd, .res_load, .res_status
  );

  cht_datapath u_dp (
    .clk, .rst_n, .cmd,
    .in_op(in_tdata[1:0]), .in_fd(in_tdata[17:2]), .in_cond(in_tdata[25:18]),
    .in_data(in_tdata[57:26]), .in_tgt(in_tdata[65:58]),
    .res_load, .res_status, .sts, .res_word
  );

  assign out_tdata = {6'd0, res_word};
endmodule

[src/cht_datapath.sv]
// datapath: link memories, node store, walk pointer and result register
`timescale 1ns / 1ps
module cht_datapath import cht_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  input  logic [1:0]  in_op,
  input  logic [15:0] in_fd,
  input  logic [7:0]  in_cond,
  input  logic [31:0] in_data,
  input  logic [7:0]  in_tgt,
  input  logic        res_load,
  input  logic [1:0]  res_status,
  output dp_status_t  sts,
  output logic [65:0] res_word
);
  logic [LW-1:0] bucket_head [BUCKETS];
  logic [LW-1:0] next_link   [POOL_ENTRIES];
  logic [LW-1:0] prev_link   [POOL_ENTRIES];
  logic [15:0]   node_fd     [POOL_ENTRIES];
  logic [7:0]    node_cond   [POOL_ENTRIES];
  logic [31:0]   node_pay    [POOL_ENTRIES];
  logic [POOL_ENTRIES-1:0] in_use_r;

  logic [1:0]    op_r;
  logic [15:0]   fd_r;
  logic [7:0]    cond_r;
  logic [31:0]   data_r;
  logic [7:0]    tgt_r;
  logic [LW-1:0] cur_r, free_r, head_r, nx_r, pv_r, fnext_r;
  logic [15:0]   rfd_r;
  logic [7:0]    rcond_r;
  logic [31:0]   rpay_r;
  logic [LW:0]   steps_r;
  logic [LW-1:0] init_r;
  logic [65:0]   res_r, res_nxt;
  logic [BW-1:0] bkt, dbkt;

  assign bkt  = fd_r[BW-1:0];
  assign dbkt = rfd_r[BW-1:0];

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_r   <= '0;
      free_r   <= '0;
      in_use_r <= '0;
    end else begin
      if (cmd == CMD_INIT && init_r != NIL) init_r <= init_r + 1'b1;
      if (cmd == CMD_ADD_WR) begin
        free_r <= fnext_r;
        in_use_r[free_r[NW-1:0]] <= 1'b1;
      end
      if (cmd == CMD_DEL_WR) begin
        in_use_r[tgt_r[NW-1:0]] <= 1'b0;
        free_r <= LW'(tgt_r);
      end
    end
  end

  // result word, fields from the low bit up
  always_comb begin
    res_nxt = '0;
    res_nxt[1:0] = res_status;
    if (res_status == ST_OK) begin
      if (op_r == OP_LOOKUP) begin
        res_nxt[9:2]   = cur_r[7:0];
        res_nxt[25:10] = rfd_r;
        res_nxt[33:26] = rcond_r;
        res_nxt[65:34] = rpay_r;
      end else if (op_r == OP_ADD) res_nxt[9:2] = cur_r[7:0];
      else res_nxt[9:2] = tgt_r;
    end
  end

  // memories and payload
  always_ff @(posedge clk) begin
    case (cmd)
      CMD_INIT: begin
        if (init_r < LW'(BUCKETS)) bucket_head[init_r[BW-1:0]] <= NIL;
        if (init_r != NIL) next_link[init_r[NW-1:0]] <= init_r + 1'b1;
      end
      CMD_LATCH: begin
        op_r <= in_op; fd_r <= in_fd; cond_r <= in_cond;
        data_r <= in_data; tgt_r <= in_tgt;
        steps_r <= '0;
      end
      CMD_RD_HEAD: begin
        head_r  <= bucket_head[bkt];
        cur_r   <= bucket_head[bkt];
        fnext_r <= next_link[free_r[NW-1:0]];
      end
      CMD_RD_NODE: begin
        rfd_r   <= node_fd[cur_r[NW-1:0]];
        rcond_r <= node_cond[cur_r[NW-1:0]];
        rpay_r  <= node_pay[cur_r[NW-1:0]];
        nx_r    <= next_link[cur_r[NW-1:0]];
      end
      CMD_STEP: begin
        cur_r   <= nx_r;
        steps_r <= steps_r + 1'b1;
      end
      CMD_ADD_WR: begin
        node_fd[free_r[NW-1:0]]   <= fd_r;
        node_cond[free_r[NW-1:0]] <= cond_r;
        node_pay[free_r[NW-1:0]]  <= data_r;
        prev_link[free_r[NW-1:0]] <= NIL;
        next_link[free_r[NW-1:0]] <= head_r;
        bucket_head[bkt]          <= free_r;
        cur_r <= free_r;
      end
      CMD_ADD_PREV: begin
        if (head_r != NIL) prev_link[head_r[NW-1:0]] <= cur_r;
      end
      CMD_DEL_RD: begin
        rfd_r <= node_fd[tgt_r[NW-1:0]];
        pv_r  <= prev_link[tgt_r[NW-1:0]];
        nx_r  <= next_link[tgt_r[NW-1:0]];
        // old link is read in the same cycle, so the target can be pushed on the free list now
        next_link[tgt_r[NW-1:0]] <= free_r;
      end
      CMD_DEL_WR: begin
        if (nx_r != NIL) prev_link[nx_r[NW-1:0]] <= pv_r;
        if (pv_r != NIL) next_link[pv_r[NW-1:0]] <= nx_r;
        else bucket_head[dbkt] <= nx_r;
      end
      default: ;
    endcase
    if (res_load) res_r <= res_nxt;
  end

  assign res_word = res_r;
  assign sts.init_done  = (init_r == NIL);
  assign sts.op         = op_r;
  assign sts.cur_nil    = (cur_r == NIL);
  assign sts.match      = (rfd_r == fd_r) && (rcond_r == cond_r);
  assign sts.walk_limit = (steps_r >= (LW+1)'(POOL_ENTRIES));
  assign sts.free_empty = (free_r == NIL);
  assign sts.tgt_used   = in_use_r[tgt_r[NW-1:0]];
endmodule

[src/cht_ctrl.sv]
// controller state machine sequencing each operation
`timescale 1ns / 1ps
module cht_ctrl import cht_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  output logic       out_tvalid,
  input  logic       out_tready,
  input  dp_status_t sts,
  output cmd_t       cmd,
  output logic       res_load,
  output logic [1:0] res_status
);
  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_HEAD, S_DISPATCH, S_RD, S_CMP, S_ADD_PREV, S_DEL_WR, S_DONE, S_OUT
  } state_t;
  state_t state_r, state_nxt;
  logic   ovalid_r;

  always_comb begin
    state_nxt  = state_r;
    cmd        = CMD_NONE;
    res_load   = 1'b0;
    res_status = ST_OK;
    unique case (state_r)
      S_INIT: begin
        cmd = CMD_INIT;
        if (sts.init_done) state_nxt = S_IDLE;
      end
      S_IDLE: if (in_tvalid) begin cmd = CMD_LATCH; state_nxt = S_HEAD; end
      S_HEAD: begin cmd = CMD_RD_HEAD; state_nxt = S_DISPATCH; end
      S_DISPATCH: begin
        unique case (sts.op)
          OP_LOOKUP: state_nxt = S_RD;
          OP_ADD: begin
            if (sts.free_empty) begin
              res_load = 1'b1; res_status = ST_FULL; state_nxt = S_OUT;
            end else begin
              cmd = CMD_ADD_WR; state_nxt = S_ADD_PREV;
            end
          end
          OP_DELETE: begin
            if (!sts.tgt_used) begin
              res_load = 1'b1; res_status = ST_NOTUSED; state_nxt = S_OUT;
            end else begin
              cmd = CMD_DEL_RD; state_nxt = S_DEL_WR;
            end
          end
          default: begin
            res_load = 1'b1; res_status = ST_NOTFOUND; state_nxt = S_OUT;
          end
        endcase
      end
      S_RD: begin
        if (sts.cur_nil || sts.walk_limit) begin
          res_load = 1'b1; res_status = ST_NOTFOUND; state_nxt = S_OUT;
        end else begin
          cmd = CMD_RD_NODE; state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        if (sts.match) begin
          res_load = 1'b1; state_nxt = S_OUT;
        end else begin
          cmd = CMD_STEP; state_nxt = S_RD;
        end
      end
      S_ADD_PREV: begin cmd = CMD_ADD_PREV; state_nxt = S_DONE; end
      S_DEL_WR:   begin cmd = CMD_DEL_WR; state_nxt = S_DONE; end
      S_DONE:     begin res_load = 1'b1; state_nxt = S_OUT; end
      S_OUT:      if (out_tready) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_INIT;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= (state_nxt == S_OUT);
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = ovalid_r;
endmodule

[bench/testbench.sv]
// self-checking bench for the chained hash table: directed and random operations checked against a table model
`timescale 1ns / 1ps
module testbench;
  import cht_pkg::*;

  typedef struct packed {
    logic [7:0]  target_node;
    logic [31:0] entry_data;
    logic [7:0]  key_condition;
    logic [15:0] key_fd;
    logic [1:0]  opcode;
  } op_item_t;

  typedef struct packed {
    logic [31:0] found_data;
    logic [7:0]  found_condition;
    logic [15:0] found_fd;
    logic [7:0]  node_index;
    logic [1:0]  status;
  } reply_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [71:0] in_tdata;  // opcode, key_fd, key_condition, entry_data, target_node
  logic        out_tvalid;
  logic        out_tready;
  logic [71:0] out_tdata;  // status, node_index, found_fd, found_condition, found_data

  chained_hash_table_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  // table model
  logic [LW-1:0] head_of[BUCKETS];
  logic [LW-1:0] nxt[POOL_ENTRIES];
  logic [LW-1:0] prv[POOL_ENTRIES];
  logic [15:0]   fd_of[POOL_ENTRIES];
  logic [7:0]    cond_of[POOL_ENTRIES];
  logic [31:0]   data_of[POOL_ENTRIES];
  logic          used[POOL_ENTRIES];
  logic [LW-1:0] free_top;

  op_item_t pending_ops[$];
  reply_t   expected_replies[$];
  int       errors;
  bit       hold_sender;
  int       send_gap;
  int       recv_gap;

  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  function automatic void table_clear();
    for (int i = 0; i < BUCKETS; i++) head_of[i] = NIL;
    for (int i = 0; i < POOL_ENTRIES; i++) begin
      nxt[i] = LW'(i + 1);
      prv[i] = '0;
      fd_of[i] = '0;
      cond_of[i] = '0;
      data_of[i] = '0;
      used[i] = 1'b0;
    end
    free_top = '0;
  endfunction

  function automatic reply_t table_apply(op_item_t it);
    reply_t r;
    logic [LW-1:0] n, h, p, nx;
    int steps;
    int b;
    r = '0;
    b = it.key_fd % BUCKETS;
    case (it.opcode)
      OP_LOOKUP: begin
        r.status = ST_NOTFOUND;
        n = head_of[b];
        steps = 0;
        while (n != NIL && steps < POOL_ENTRIES) begin
          if (fd_of[n] == it.key_fd && cond_of[n] == it.key_condition) begin
            r.status = ST_OK;
            r.node_index = n[7:0];
            r.found_fd = fd_of[n];
            r.found_condition = cond_of[n];
            r.found_data = data_of[n];
            break;
          end
          n = nxt[n];
          steps++;
        end
      end
      OP_ADD: begin
        n = free_top;
        if (n == NIL) begin
          r.status = ST_FULL;
        end else begin
          free_top = nxt[n];
          fd_of[n] = it.key_fd;
          cond_of[n] = it.key_condition;
          data_of[n] = it.entry_data;
          used[n] = 1'b1;
          h = head_of[b];
          prv[n] = NIL;
          nxt[n] = h;
          if (h != NIL) prv[h] = n;
          head_of[b] = n;
          r.status = ST_OK;
          r.node_index = n[7:0];
        end
      end
      OP_DELETE: begin
        if (!used[it.target_node]) begin
          r.status = ST_NOTUSED;
        end else begin
          p = prv[it.target_node];
          nx = nxt[it.target_node];
          if (nx != NIL) prv[nx] = p;
          if (p != NIL) nxt[p] = nx;
          else head_of[fd_of[it.target_node] % BUCKETS] = nx;
          used[it.target_node] = 1'b0;
          nxt[it.target_node] = free_top;
          free_top = LW'(it.target_node);
          r.status = ST_OK;
          r.node_index = it.target_node;
        end
      end
      default: r.status = ST_NOTFOUND;
    endcase
    return r;
  endfunction

  function automatic op_item_t mk_op(logic [1:0] op, logic [15:0] fd, logic [7:0] cond,
                                     logic [31:0] data, logic [7:0] tgt);
    op_item_t it;
    it.opcode = op;
    it.key_fd = fd;
    it.key_condition = cond;
    it.entry_data = data;
    it.target_node = tgt;
    return it;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      send_gap <= 0;
    end else if (in_tvalid && !in_tready) begin
    end else if (send_gap > 0) begin
      in_tvalid <= 1'b0;
      send_gap <= send_gap - 1;
    end else if (pending_ops.size() > 0 && !hold_sender) begin
      in_tvalid <= 1'b1;
      in_tdata <= {6'd0, pending_ops.pop_front()};
      send_gap <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 15);
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // predict on acceptance
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      expected_replies.push_back(table_apply(op_item_t'(in_tdata[65:0])));
  end

  // monitor
  always @(posedge clk) begin
    reply_t got, want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      recv_gap <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = reply_t'(out_tdata[65:0]);
        if (expected_replies.size() == 0) begin
          $error("unexpected result item %h", out_tdata);
          errors++;
        end else begin
          want = expected_replies.pop_front();
          if (got.status !== want.status) begin
            $error("status exp %0d got %0d", want.status, got.status); errors++;
          end
          if (got.node_index !== want.node_index) begin
            $error("node_index exp %0d got %0d", want.node_index, got.node_index); errors++;
          end
          if (got.found_fd !== want.found_fd) begin
            $error("found_fd exp %h got %h", want.found_fd, got.found_fd); errors++;
          end
          if (got.found_condition !== want.found_condition) begin
            $error("found_condition exp %h got %h", want.found_condition, got.found_condition);
            errors++;
          end
          if (got.found_data !== want.found_data) begin
            $error("found_data exp %h got %h", want.found_data, got.found_data); errors++;
          end
        end
      end
      if (recv_gap > 0) begin
        out_tready <= 1'b0;
        recv_gap <= recv_gap - 1;
      end else if (out_tready && out_tvalid) begin
        recv_gap <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 15);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    logic [15:0] fds[$];
    logic [7:0]  conds[$];
    int k, sel;
    logic [15:0] f;
    errors = 0;
    hold_sender = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    table_clear();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: misses, extremes, collisions, deletes of unused nodes, opcode 3
    pending_ops.push_back(mk_op(OP_LOOKUP, 16'h0000, 8'h00, '0, '0));
    pending_ops.push_back(mk_op(OP_DELETE, 16'hffff, 8'hff, '1, 8'h00));
    pending_ops.push_back(mk_op(OP_DELETE, 16'h0000, 8'h00, '0, 8'hff));
    pending_ops.push_back(mk_op(OP_ADD, 16'h0000, 8'h00, 32'h0000_0000, 8'h00));
    pending_ops.push_back(mk_op(OP_ADD, 16'hffff, 8'hff, 32'hffff_ffff, 8'hff));
    pending_ops.push_back(mk_op(OP_ADD, 16'h0080, 8'h00, 32'h1234_5678, 8'h00));
    pending_ops.push_back(mk_op(OP_ADD, 16'h0000, 8'h01, 32'hdead_beef, 8'h00));
    pending_ops.push_back(mk_op(OP_ADD, 16'h0000, 8'h00, 32'hcafe_f00d, 8'h00));
    pending_ops.push_back(mk_op(OP_LOOKUP, 16'h0000, 8'h00, '0, '0));
    pending_ops.push_back(mk_op(OP_LOOKUP, 16'h0080, 8'h00, '0, '0));
    pending_ops.push_back(mk_op(OP_LOOKUP, 16'hffff, 8'hff, '1, '1));
    pending_ops.push_back(mk_op(OP_LOOKUP, 16'h0000, 8'h02, '0, '0));
    pending_ops.push_back(mk_op(2'd3, 16'hffff, 8'hff, '1, '1));
    pending_ops.push_back(mk_op(OP_DELETE, 16'h0000, 8'h00, '0, 8'd4));  // chain head
    pending_ops.push_back(mk_op(OP_DELETE, 16'h0000, 8'h00, '0, 8'd0));  // chain tail
    pending_ops.push_back(mk_op(OP_DELETE, 16'h0000, 8'h00, '0, 8'd0));  // already free
    pending_ops.push_back(mk_op(OP_LOOKUP, 16'h0000, 8'h00, '0, '0));
    pending_ops.push_back(mk_op(OP_LOOKUP, 16'h0000, 8'h01, '0, '0));
    pending_ops.push_back(mk_op(OP_DELETE, 16'h0000, 8'h00, '0, 8'd2));  // tail of the remaining chain
    pending_ops.push_back(mk_op(OP_LOOKUP, 16'h0080, 8'h00, '0, '0));
    while (pending_ops.size() > 0 || expected_replies.size() > 0 || in_tvalid) @(posedge clk);

    // fill the pool until it reports full, then pause until drained
    for (int i = 0; i < 260; i++) begin
      f = 16'($urandom_range(0, 65535));
      fds.push_back(f);
      conds.push_back(8'($urandom_range(0, 255)));
      pending_ops.push_back(mk_op(OP_ADD, f, conds[$], $urandom, 8'($urandom)));
    end
    while (pending_ops.size() > 0 || in_tvalid) @(posedge clk);
    hold_sender = 1;
    while (expected_replies.size() > 0) @(posedge clk);
    hold_sender = 0;
    for (int i = 0; i < 256; i++)
      pending_ops.push_back(mk_op(OP_DELETE, 16'($urandom), 8'($urandom), $urandom, i[7:0]));

    // random mix, keys mostly from a small reused set so lookups hit and chains grow
    for (k = 0; k < 560; k++) begin
      sel = $urandom_range(0, 99);
      if (fds.size() > 0 && sel < 70) begin
        int j;
        j = $urandom_range(0, fds.size() - 1);
        f = fds[j];
        if ($urandom_range(0, 3) == 0) f = {f[15:7] ^ 9'($urandom), f[6:0]};
        pending_ops.push_back(mk_op(logic'($urandom_range(0, 1)) ? OP_ADD : OP_LOOKUP,
                                    f, $urandom_range(0, 9) == 0 ? 8'($urandom) : conds[j],
                                    $urandom, 8'($urandom)));
      end else if (sel < 92) begin
        pending_ops.push_back(mk_op(OP_DELETE, 16'($urandom), 8'($urandom), $urandom,
                                    8'($urandom_range(0, 63))));
      end else begin
        pending_ops.push_back(mk_op(2'($urandom), 16'($urandom), 8'($urandom), $urandom,
                                    8'($urandom)));
      end
    end
    while (pending_ops.size() > 0 || expected_replies.size() > 0 || in_tvalid) @(posedge clk);
    repeat (1200) @(posedge clk);
    if (errors == 0 && expected_replies.size() == 0) begin
      $display("PASS chained_hash_table_top");
    end else begin
      $display("FAIL chained_hash_table_top");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("FAIL chained_hash_table_top");
    $finish;
  end
endmodule
